[rtl/core/pfcs_pkg.sv]
package pfcs_pkg;

    // Digit accumulators are limited to 2^(NUM_BITS-1)-1; a digit that would pass it is a parse error
    localparam int NUM_BITS = 32;
    localparam int DIG_W    = NUM_BITS - 1;
    localparam int ACC_W    = (DIG_W > 32) ? DIG_W : 32;
    localparam int PROD_W   = DIG_W + 4;

    localparam logic [PROD_W-1:0] ACC_LIMIT = {{(PROD_W - DIG_W){1'b0}}, {DIG_W{1'b1}}};

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_WDIG,
        PH_AFTW,
        PH_DOT,
        PH_PDIG,
        PH_AFTP
    } t_phase;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_OPEN,
        ACT_MINUS,
        ACT_ZERO,
        ACT_STAR_W,
        ACT_DIG_W,
        ACT_DOT,
        ACT_STAR_P,
        ACT_DIG_P,
        ACT_FINISH,
        ACT_ERROR,
        ACT_EOS,
        ACT_CLEAR
    } t_action;

    typedef struct packed {
        logic       is_pct;
        logic       is_minus;
        logic       is_zero;
        logic       is_star;
        logic       is_dot;
        logic       is_digit;
        logic       is_numeric;
        logic       is_spec;
        logic [3:0] digit;
    } t_class;

    typedef struct packed {
        logic [7:0]         spec_char;
        logic               left_align;
        logic               zero_pad;
        logic               has_precision;
        logic signed [31:0] field_width;
        logic signed [31:0] prec_value;
        logic               parse_error;
    } t_result;

endpackage

[rtl/core/pfcs_char_class.sv]
module pfcs_char_class (
    input  logic [7:0]      i_char,
    output pfcs_pkg::t_class o_class
);
    import pfcs_pkg::*;

    always_comb begin
        o_class            = '0;
        o_class.is_pct     = (i_char == CH_PCT);
        o_class.is_minus   = (i_char == CH_MINUS);
        o_class.is_zero    = (i_char == CH_0);
        o_class.is_star    = (i_char == CH_STAR);
        o_class.is_dot     = (i_char == CH_DOT);
        o_class.is_digit   = (i_char >= CH_0) && (i_char <= CH_9);
        o_class.digit      = i_char[3:0];
        unique case (i_char) inside
            CH_D, CH_I, CH_U, CH_X, CH_UX: begin
                o_class.is_numeric = 1'b1;
                o_class.is_spec    = 1'b1;
            end
            CH_C, CH_S, CH_P, CH_PCT: begin
                o_class.is_spec = 1'b1;
            end
            default: begin
                o_class.is_spec = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/pfcs_step.sv]
module pfcs_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_char,
    input  logic signed [31:0]  i_star,
    input  logic                i_eos,
    output logic                o_emit,
    output pfcs_pkg::t_result   o_result
);
    import pfcs_pkg::*;

    t_phase              r_phase, n_phase;
    logic                r_halted, n_halted;
    logic                r_fl_minus, n_fl_minus;
    logic                r_fl_zero, n_fl_zero;
    logic                r_fl_dot, n_fl_dot;
    logic [ACC_W-1:0]    r_width, n_width;
    logic [ACC_W-1:0]    r_prec, n_prec;

    t_class              cls;
    t_action             act;
    logic [DIG_W-1:0]    dig_base;
    logic [PROD_W-1:0]   prod;
    logic                dig_ovf;
    logic                star_bad;
    t_action             fin_act;

    pfcs_char_class u_class (
        .i_char  (i_char),
        .o_class (cls)
    );

    // Width digits start from zero straight after the flags
    always_comb begin
        case (r_phase)
            PH_WDIG: dig_base = r_width[DIG_W-1:0];
            PH_PDIG: dig_base = r_prec[DIG_W-1:0];
            default: dig_base = '0;
        endcase
    end

    assign prod     = (PROD_W'(dig_base) << 3) + (PROD_W'(dig_base) << 1) + PROD_W'(cls.digit);
    assign dig_ovf  = prod > ACC_LIMIT;
    assign star_bad = i_star[31] && r_fl_zero;
    assign fin_act  = cls.is_spec ? ACT_FINISH : ACT_ERROR;

    always_comb begin
        act = ACT_NONE;
        if (i_eos) begin
            act = ACT_EOS;
        end else if (!r_halted) begin
            unique case (r_phase)
                PH_IDLE: begin
                    act = cls.is_pct ? ACT_OPEN : ACT_NONE;
                end
                PH_FLAGS: begin
                    if (cls.is_minus)      act = ACT_MINUS;
                    else if (cls.is_zero)  act = ACT_ZERO;
                    else if (cls.is_star)  act = star_bad ? ACT_ERROR : ACT_STAR_W;
                    else if (cls.is_digit) act = dig_ovf ? ACT_ERROR : ACT_DIG_W;
                    else if (cls.is_dot)   act = ACT_DOT;
                    else                   act = fin_act;
                end
                PH_WDIG: begin
                    if (cls.is_digit)      act = dig_ovf ? ACT_ERROR : ACT_DIG_W;
                    else if (cls.is_dot)   act = ACT_DOT;
                    else                   act = fin_act;
                end
                PH_AFTW: begin
                    act = cls.is_dot ? ACT_DOT : fin_act;
                end
                PH_DOT: begin
                    if (cls.is_star)       act = star_bad ? ACT_ERROR : ACT_STAR_P;
                    else if (cls.is_digit) act = dig_ovf ? ACT_ERROR : ACT_DIG_P;
                    else                   act = fin_act;
                end
                PH_PDIG: begin
                    act = cls.is_digit ? (dig_ovf ? ACT_ERROR : ACT_DIG_P) : fin_act;
                end
                PH_AFTP: begin
                    act = fin_act;
                end
                default: begin
                    act = ACT_CLEAR;
                end
            endcase
        end
    end

    // Next phase
    always_comb begin
        n_phase  = r_phase;
        n_halted = r_halted;
        unique case (act)
            ACT_NONE, ACT_MINUS, ACT_ZERO: n_phase = r_phase;
            ACT_OPEN:                      n_phase = PH_FLAGS;
            ACT_STAR_W:                    n_phase = PH_AFTW;
            ACT_DIG_W:                     n_phase = PH_WDIG;
            ACT_DOT:                       n_phase = PH_DOT;
            ACT_STAR_P:                    n_phase = PH_AFTP;
            ACT_DIG_P:                     n_phase = PH_PDIG;
            ACT_FINISH, ACT_CLEAR:         n_phase = PH_IDLE;
            ACT_ERROR: begin
                n_phase  = PH_IDLE;
                n_halted = 1'b1;
            end
            ACT_EOS: begin
                n_phase  = PH_IDLE;
                n_halted = 1'b0;
            end
            default:                       n_phase = PH_IDLE;
        endcase
    end

    // Conversion fields and result
    always_comb begin
        n_fl_minus = r_fl_minus;
        n_fl_zero  = r_fl_zero;
        n_fl_dot   = r_fl_dot;
        n_width    = r_width;
        n_prec     = r_prec;
        o_emit     = 1'b0;
        o_result   = '0;
        unique case (act)
            ACT_NONE: begin
                o_emit = 1'b0;
            end
            ACT_MINUS: n_fl_minus = 1'b1;
            ACT_ZERO:  n_fl_zero  = 1'b1;
            ACT_STAR_W: n_width = ACC_W'($unsigned(i_star));
            ACT_DIG_W:  n_width = ACC_W'(prod[DIG_W-1:0]);
            ACT_DOT: begin
                n_fl_dot = 1'b1;
                n_prec   = '0;
            end
            ACT_STAR_P: n_prec = ACC_W'($unsigned(i_star));
            ACT_DIG_P:  n_prec = ACC_W'(prod[DIG_W-1:0]);
            ACT_FINISH: begin
                o_emit                 = 1'b1;
                o_result.spec_char     = i_char;
                o_result.left_align    = r_fl_minus;
                o_result.zero_pad      = r_fl_zero && !(r_fl_minus || (cls.is_numeric && r_fl_dot));
                o_result.has_precision = r_fl_dot;
                o_result.field_width   = r_width[31:0];
                o_result.prec_value    = r_prec[31:0];
            end
            ACT_ERROR: begin
                o_emit               = 1'b1;
                o_result.parse_error = 1'b1;
            end
            ACT_EOS: begin
                // string cut short inside a conversion
                o_emit               = !r_halted && (r_phase != PH_IDLE);
                o_result.parse_error = o_emit;
            end
            ACT_OPEN, ACT_CLEAR: begin
                o_emit = 1'b0;
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
        if (act == ACT_OPEN || act == ACT_FINISH || act == ACT_ERROR ||
            act == ACT_EOS || act == ACT_CLEAR) begin
            n_fl_minus = 1'b0;
            n_fl_zero  = 1'b0;
            n_fl_dot   = 1'b0;
            n_width    = '0;
            n_prec     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_halted   <= 1'b0;
            r_fl_minus <= 1'b0;
            r_fl_zero  <= 1'b0;
            r_fl_dot   <= 1'b0;
            r_width    <= '0;
            r_prec     <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_halted   <= n_halted;
            r_fl_minus <= n_fl_minus;
            r_fl_zero  <= n_fl_zero;
            r_fl_dot   <= n_fl_dot;
            r_width    <= n_width;
            r_prec     <= n_prec;
        end
    end

endmodule

[rtl/core/printf_conversion_spec_parser_unit.sv]
// A result beat goes from the input register through the parse step into the result
// register; a stall on the result side can hold it in the input register.
// Throughput: one input beat per cycle while the result side is not stalled; the
// combinational parse step between the input register and the result register allows this.
// Reset (i_rst_n low, synchronous): parser outside any conversion, not halted,
// both register stages empty.
module printf_conversion_spec_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_in,
    input  logic signed [31:0] i_star_value,
    input  logic               i_end_of_string,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_spec_char,
    output logic               o_left_align,
    output logic               o_zero_pad,
    output logic               o_has_precision,
    output logic signed [31:0] o_field_width,
    output logic signed [31:0] o_prec_value,
    output logic               o_parse_error
);
    import pfcs_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic signed [31:0] r_in_star;
    logic               r_in_eos;
    logic               r_out_valid;
    t_result            r_out;

    logic               move;
    logic               accept;
    logic               step_emit;
    t_result            step_result;

    // Input stage advances whenever the result register is free or draining
    assign move    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    pfcs_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (move),
        .i_char   (r_in_char),
        .i_star   (r_in_star),
        .i_eos    (r_in_eos),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_in;
            r_in_star <= i_star_value;
            r_in_eos  <= i_end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= step_emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_spec_char     = r_out.spec_char;
    assign o_left_align    = r_out.left_align;
    assign o_zero_pad      = r_out.zero_pad;
    assign o_has_precision = r_out.has_precision;
    assign o_field_width   = r_out.field_width;
    assign o_prec_value    = r_out.prec_value;
    assign o_parse_error   = r_out.parse_error;

endmodule

[rtl/core/pfcs_checker.sv]
module pfcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [7:0]         o_spec_char,
    input logic               o_left_align,
    input logic               o_zero_pad,
    input logic               o_has_precision,
    input logic signed [31:0] o_field_width,
    input logic signed [31:0] o_prec_value,
    input logic               o_parse_error
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_spec_char) && $stable(o_field_width)
            && $stable(o_prec_value) && $stable(o_parse_error))
        else $error("result beat changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parse_error |-> o_spec_char == 8'd0 && !o_left_align && !o_zero_pad
            && !o_has_precision && o_field_width == 32'sd0 && o_prec_value == 32'sd0)
        else $error("error beat carries non-zero fields");

    a_pad_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_parse_error |-> !(o_zero_pad && o_left_align))
        else $error("zero pad kept with left align");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty result stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat offered after reset");

endmodule

bind printf_conversion_spec_parser_unit pfcs_checker u_pfcs_checker (.*);

[tb/printf_conversion_spec_parser_unit_tb.sv]
module printf_conversion_spec_parser_unit_tb;
    import pfcs_pkg::*;

    localparam logic [63:0] DIGIT_CEIL = (64'd1 << (NUM_BITS - 1)) - 64'd1;
    localparam int unsigned RANDOM_BEATS = 1650;
    localparam int unsigned TAIL_CYCLES = 8;

    typedef struct {
        logic [7:0]  ch;
        logic [31:0] star;
        logic        eos;
        int unsigned gap_after;
        bit          drain;
    } t_format_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_char_in = 8'h00;
    logic signed [31:0] i_star_value = 32'sd0;
    logic               i_end_of_string = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_spec_char;
    logic               o_left_align;
    logic               o_zero_pad;
    logic               o_has_precision;
    logic signed [31:0] o_field_width;
    logic signed [31:0] o_prec_value;
    logic               o_parse_error;

    printf_conversion_spec_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_in       (i_char_in),
        .i_star_value    (i_star_value),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_spec_char     (o_spec_char),
        .o_left_align    (o_left_align),
        .o_zero_pad      (o_zero_pad),
        .o_has_precision (o_has_precision),
        .o_field_width   (o_field_width),
        .o_prec_value    (o_prec_value),
        .o_parse_error   (o_parse_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Parser state as the block should hold it
    t_phase      cv_phase;
    logic        cv_minus;
    logic        cv_zero;
    logic        cv_dot;
    logic [63:0] cv_width;
    logic [63:0] cv_prec;
    logic        cv_halted;

    t_result      spec_records_due[$];
    t_format_beat format_beats[$];
    t_format_beat cur_beat;

    int unsigned gap_left = 0;
    int unsigned beats_taken = 0;
    int unsigned beats_total = 0;
    int unsigned stall_left = 0;
    int unsigned free_left = 0;
    int          mismatches = 0;
    logic        beat_taken = 1'b0;
    bit          calm = 1'b0;
    bit          drain_next = 1'b0;

    task automatic clear_conversion();
        cv_phase = PH_IDLE;
        cv_minus = 1'b0;
        cv_zero  = 1'b0;
        cv_dot   = 1'b0;
        cv_width = '0;
        cv_prec  = '0;
    endtask

    task automatic raise_parse_error();
        t_result r;
        r = '0;
        r.parse_error = 1'b1;
        spec_records_due.push_back(r);
        clear_conversion();
        cv_halted = 1'b1;
    endtask

    function automatic bit digit_fits(input logic [63:0] acc, input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c} - {56'd0, CH_0};
        return !(d > DIGIT_CEIL || acc > (DIGIT_CEIL - d) / 64'd10);
    endfunction

    task automatic take_digit(input logic [7:0] c, input bit into_prec);
        logic [63:0] d;
        d = {56'd0, c} - {56'd0, CH_0};
        if (!digit_fits(into_prec ? cv_prec : cv_width, c)) begin
            raise_parse_error();
        end else if (into_prec) begin
            cv_prec  = cv_prec * 64'd10 + d;
            cv_phase = PH_PDIG;
        end else begin
            cv_width = cv_width * 64'd10 + d;
            cv_phase = PH_WDIG;
        end
    endtask

    task automatic take_star(input logic [31:0] v, input bit into_prec);
        if (v[31] && cv_zero) begin
            raise_parse_error();
        end else if (into_prec) begin
            cv_prec  = {32'd0, v};
            cv_phase = PH_AFTP;
        end else begin
            cv_width = {32'd0, v};
            cv_phase = PH_AFTW;
        end
    endtask

    task automatic close_conversion(input logic [7:0] c);
        bit      numeric;
        t_result r;
        numeric = c inside {CH_D, CH_I, CH_U, CH_X, CH_UX};
        if (!(numeric || c inside {CH_C, CH_S, CH_P, CH_PCT})) begin
            raise_parse_error();
        end else begin
            r.spec_char     = c;
            r.left_align    = cv_minus;
            // minus, or a precision on an integer conversion, overrides zero padding
            r.zero_pad      = cv_zero && !(cv_minus || (numeric && cv_dot));
            r.has_precision = cv_dot;
            r.field_width   = cv_width[31:0];
            r.prec_value    = cv_prec[31:0];
            r.parse_error   = 1'b0;
            spec_records_due.push_back(r);
            clear_conversion();
        end
    endtask

    task automatic parse_format_byte(input logic [7:0] c, input logic [31:0] star,
                                     input logic eos);
        bit is_dig;
        is_dig = (c >= CH_0) && (c <= CH_9);
        if (eos) begin
            if (!cv_halted && cv_phase != PH_IDLE)
                raise_parse_error();
            clear_conversion();
            cv_halted = 1'b0;
        end else if (!cv_halted) begin
            case (cv_phase)
                PH_IDLE: begin
                    if (c == CH_PCT) begin
                        clear_conversion();
                        cv_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS, PH_WDIG, PH_AFTW: begin
                    if (cv_phase == PH_FLAGS && c == CH_MINUS)
                        cv_minus = 1'b1;
                    else if (cv_phase == PH_FLAGS && c == CH_0)
                        cv_zero = 1'b1;
                    else if (cv_phase == PH_FLAGS && c == CH_STAR)
                        take_star(star, 1'b0);
                    else if (cv_phase != PH_AFTW && is_dig)
                        take_digit(c, 1'b0);
                    else if (c == CH_DOT) begin
                        cv_dot   = 1'b1;
                        cv_prec  = '0;
                        cv_phase = PH_DOT;
                    end else
                        close_conversion(c);
                end
                PH_DOT, PH_PDIG: begin
                    if (cv_phase == PH_DOT && c == CH_STAR)
                        take_star(star, 1'b1);
                    else if (is_dig)
                        take_digit(c, 1'b1);
                    else
                        close_conversion(c);
                end
                PH_AFTP: close_conversion(c);
                default: clear_conversion();
            endcase
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_star();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 99);
            3, 4:    return 32'd0 - $urandom_range(1, 99);
            5: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_beat(input logic [7:0] c, input logic [31:0] star, input logic eos);
        t_format_beat b;
        b.ch        = c;
        b.star      = star;
        b.eos       = eos;
        b.gap_after = calm ? 0 : pick_gap();
        b.drain     = drain_next;
        drain_next  = 1'b0;
        format_beats.push_back(b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i])
            add_beat(s[i], $urandom, 1'b0);
    endtask

    task automatic add_eos();
        add_beat(8'($urandom_range(0, 255)), $urandom, 1'b1);
    endtask

    // Width digits must not start with '0', which would read as the zero flag
    task automatic add_number(input bit first_nonzero);
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            add_text("2147483647");
        end else if (r < 8) begin
            add_text("2147483648");
        end else begin
            len = (r < 88) ? $urandom_range(1, 3) : $urandom_range(9, 11);
            for (int unsigned i = 0; i < len; i++)
                add_beat(8'(CH_0 + ((i == 0 && first_nonzero) ? $urandom_range(1, 9)
                                                               : $urandom_range(0, 9))),
                         $urandom, 1'b0);
        end
    endtask

    task automatic add_conversion(output bit cut);
        string       specs;
        int unsigned nflags;
        int unsigned r;
        specs = "cspdiuxX%";
        cut = 1'b0;
        add_beat(CH_PCT, $urandom, 1'b0);
        nflags = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int unsigned i = 0; i < nflags; i++)
            add_beat($urandom_range(0, 1) ? CH_MINUS : CH_0, $urandom, 1'b0);
        r = $urandom_range(0, 9);
        if (r >= 8)
            add_beat(CH_STAR, pick_star(), 1'b0);
        else if (r >= 4)
            add_number(1'b1);
        if ($urandom_range(0, 1)) begin
            add_beat(CH_DOT, $urandom, 1'b0);
            r = $urandom_range(0, 9);
            if (r >= 7)
                add_beat(CH_STAR, pick_star(), 1'b0);
            else if (r >= 3)
                add_number(1'b0);
        end
        if ($urandom_range(0, 24) == 0) begin
            cut = 1'b1;
        end else if ($urandom_range(0, 99) < 88) begin
            add_beat(specs[$urandom_range(0, 8)], $urandom, 1'b0);
        end else begin
            add_beat(8'($urandom_range(0, 255)), $urandom, 1'b0);
        end
    endtask

    task automatic add_plain_text(input int unsigned len);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            add_beat((b == CH_PCT) ? 8'h20 : b, $urandom, 1'b0);
        end
    endtask

    // Input side: a new beat is offered only once the previous one was taken
    always @(posedge i_clk)
        beat_taken <= i_rst_n && i_valid && !o_stall;

    always @(negedge i_clk) begin : drive_format
        if (i_rst_n) begin
            if (beat_taken) begin
                parse_format_byte(cur_beat.ch, cur_beat.star, cur_beat.eos);
                beats_taken++;
            end
            if (!i_valid || beat_taken) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (format_beats.size() != 0 &&
                             !(format_beats[0].drain && spec_records_due.size() != 0)) begin
                    cur_beat = format_beats.pop_front();
                    gap_left = cur_beat.gap_after;
                    i_valid         <= 1'b1;
                    i_char_in       <= cur_beat.ch;
                    i_star_value    <= cur_beat.star;
                    i_end_of_string <= cur_beat.eos;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_stall
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (free_left != 0) begin
            i_stall <= 1'b0;
            free_left--;
        end else begin
            free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 6);
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(1, 3);
            i_stall <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_records
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (spec_records_due.size() == 0) begin
                $error("result beat with no record pending");
                mismatches++;
            end else begin
                want = spec_records_due.pop_front();
                compare_field("spec_char", 32'(want.spec_char), 32'(o_spec_char));
                compare_field("left_align", 32'(want.left_align), 32'(o_left_align));
                compare_field("zero_pad", 32'(want.zero_pad), 32'(o_zero_pad));
                compare_field("has_precision", 32'(want.has_precision),
                              32'(o_has_precision));
                compare_field("field_width", want.field_width, o_field_width);
                compare_field("prec_value", want.prec_value, o_prec_value);
                compare_field("parse_error", 32'(want.parse_error), 32'(o_parse_error));
            end
        end
    end

    initial begin
        int unsigned first_random;
        int unsigned segs;
        bit          cut;

        clear_conversion();
        cv_halted = 1'b0;

        // negative star with zero flag, then a byte that must be ignored
        add_text("%0");
        add_beat(CH_STAR, 32'h8000_0000, 1'b0);
        add_beat(8'hFF, $urandom, 1'b0);
        add_eos();
        // negative star without zero flag is kept; then a truncated conversion
        add_text("%-");
        add_beat(CH_STAR, 32'h7FFF_FFFF, 1'b0);
        add_text(".");
        add_beat(CH_STAR, 32'hFFFF_FFF9, 1'b0);
        add_text("u%.");
        add_eos();
        // width one past the signed limit
        add_text("%2147483648");
        add_eos();
        // zero byte as specifier
        add_text("%");
        add_beat(8'h00, $urandom, 1'b0);
        add_eos();
        add_text("%s%p%X%%");

        first_random = format_beats.size();
        drain_next = 1'b1;
        while (format_beats.size() - first_random < RANDOM_BEATS) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 19) == 0)
                drain_next = 1'b1;
            if ($urandom_range(0, 9) != 0) begin
                segs = $urandom_range(1, 5);
                cut = 1'b0;
                for (int unsigned s = 0; s < segs && !cut; s++) begin
                    if ($urandom_range(0, 1))
                        add_plain_text($urandom_range(1, 4));
                    add_conversion(cut);
                end
                if (!cut && $urandom_range(0, 1))
                    add_plain_text($urandom_range(1, 3));
                add_eos();
            end else begin
                // noise: loose bytes, biased towards format characters
                segs = $urandom_range(3, 20);
                for (int unsigned s = 0; s < segs; s++) begin
                    string noise_chars;
                    noise_chars = "%-0*.129dxq";
                    add_beat($urandom_range(0, 1) ? noise_chars[$urandom_range(0, 10)]
                                                  : 8'($urandom_range(0, 255)),
                             pick_star(), 1'b0);
                end
                if ($urandom_range(0, 1))
                    add_eos();
            end
        end
        beats_total = format_beats.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < beats_total || spec_records_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (spec_records_due.size() != 0) begin
            $error("%0d records never arrived", spec_records_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("printf_conversion_spec_parser_unit_tb: done, clean");
        else
            $display("printf_conversion_spec_parser_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("printf_conversion_spec_parser_unit_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/pfcs_pkg.sv
rtl/core/pfcs_char_class.sv
rtl/core/pfcs_step.sv
rtl/core/printf_conversion_spec_parser_unit.sv
rtl/core/pfcs_checker.sv
tb/printf_conversion_spec_parser_unit_tb.sv
